// File: hw/rtl/idp_pkg.sv
package idp_pkg;

    // parser phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_PROTO  = 3'd2;
    localparam logic [2:0] PH_SIZE   = 3'd3;
    localparam logic [2:0] PH_CNT_HI = 3'd4;
    localparam logic [2:0] PH_CNT_LO = 3'd5;
    localparam logic [2:0] PH_SPI    = 3'd6;

    // result status codes
    localparam logic [2:0] ST_SPI      = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_BADSIZE  = 3'd3;
    localparam logic [2:0] ST_BADCOUNT = 3'd4;
    localparam logic [2:0] ST_MISMATCH = 3'd5;
    localparam logic [2:0] ST_BADPROTO = 3'd6;

    // protocol ids
    localparam logic [7:0] PID_IKE = 8'd1;
    localparam logic [7:0] PID_AH  = 8'd2;
    localparam logic [7:0] PID_ESP = 8'd3;

    localparam logic [15:0] MIN_LENGTH = 16'd8;
    localparam logic [7:0]  SPI_BYTES  = 8'd4;
    localparam logic [1:0]  SPI_LAST_BYTE = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] spi_val;
        logic [15:0] spi_index;
        logic [7:0]  proto_num;
        logic        last_flag;
    } idp_result_t;

endpackage

// File: hw/rtl/idp_byte_if.sv
interface idp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_flag;

    modport source (output valid, output data_byte, output start_flag, input ready);
    modport sink (input valid, input data_byte, input start_flag, output ready);
endinterface

// File: hw/rtl/idp_result_if.sv
interface idp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] spi_val;
    logic [15:0] spi_index;
    logic [7:0]  proto_num;
    logic        last_flag;

    modport source (output valid, output status, output spi_val, output spi_index,
                    output proto_num, output last_flag, input ready);
    modport sink (input valid, input status, input spi_val, input spi_index,
                  input proto_num, input last_flag, output ready);
endinterface

// File: hw/rtl/ikev2_delete_payload_parser_top.sv
// ikev2 delete payload body parser
// body: byte channel, one word per payload byte starting at the length high
//   byte; start_flag set on that first byte restarts parsing at any time
// result: one word per spi (status 0, value, index, last_flag on the final
//   one), or one done word for an empty payload, or one error word, after
//   which body bytes are dropped until the next start_flag
// proto_num on every result is the header protocol byte (0 if not yet read)
// path: an accepted byte waits in the input register until the parser steps,
//   and its result word is then held in the result register
// throughput: one byte per cycle while results are taken; the input register
//   and the result register each hold one word, and the parser steps whenever
//   the result register is empty or being emptied in the same cycle
// stall: while the result register is full and not taken, the parser holds;
//   one more byte is still taken into the input register, then body.ready drops
// reset: asynchronous, both registers empty, parser idle waiting for a start
module ikev2_delete_payload_parser_top
    import idp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    idp_byte_if.sink     body,
    idp_result_if.source result
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    idp_result_t out_reg;

    logic        step;
    logic        res_valid;
    idp_result_t res;
    logic        body_accept;

    // parse the held byte when the result slot is free or drains this cycle
    assign step        = in_valid_reg && (!out_valid_reg || result.ready);
    assign body.ready  = !in_valid_reg || step;
    assign body_accept = body.valid && body.ready;

    idp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step),
        .data_byte  (in_byte_reg),
        .start_flag (in_start_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (body_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = res_valid;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (body_accept)
        begin
            in_byte_reg  <= body.data_byte;
            in_start_reg <= body.start_flag;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_reg.status;
    assign result.spi_val     = out_reg.spi_val;
    assign result.spi_index   = out_reg.spi_index;
    assign result.proto_num   = out_reg.proto_num;
    assign result.last_flag   = out_reg.last_flag;

endmodule

// File: hw/rtl/idp_parser.sv
module idp_parser
    import idp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [7:0]  data_byte,
    input  logic        start_flag,
    output logic        res_valid,
    output idp_result_t res
);

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  proto_reg, proto_next;
    logic [7:0]  size_reg, size_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] ctr_reg, ctr_next;
    logic [1:0]  bis_reg, bis_next;
    logic [31:0] shift_reg, shift_next;

    logic [15:0] len_full;
    logic [15:0] cnt_full;
    logic [23:0] prod;
    logic [24:0] expect_len;
    logic        last_spi;

    assign len_full   = {len_reg[15:8], data_byte};
    assign cnt_full   = {count_reg[15:8], data_byte};
    assign prod       = 24'(cnt_full) * 24'(size_reg);
    assign expect_len = {1'b0, prod} + 25'(MIN_LENGTH);
    assign last_spi   = ({1'b0, ctr_reg} + 17'd1) >= {1'b0, count_reg};

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        proto_next = proto_reg;
        size_next  = size_reg;
        count_next = count_reg;
        ctr_next   = ctr_reg;
        bis_next   = bis_reg;
        shift_next = shift_reg;
        res_valid  = 1'b0;
        res.status      = ST_DONE;
        res.spi_val     = '0;
        res.spi_index   = '0;
        res.proto_num   = proto_reg;
        res.last_flag   = 1'b1;

        if (step_en)
        begin
            if (start_flag)
            begin
                len_next   = {data_byte, 8'h00};
                proto_next = '0;
                size_next  = '0;
                count_next = '0;
                ctr_next   = '0;
                bis_next   = '0;
                shift_next = '0;
                phase_next = PH_LEN_LO;
            end
            else
            begin
                case (phase_reg)
                    PH_LEN_LO:
                    begin
                        len_next = len_full;
                        if (len_full < MIN_LENGTH)
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.status = ST_SHORT;
                        end
                        else
                        begin
                            phase_next = PH_PROTO;
                        end
                    end
                    PH_PROTO:
                    begin
                        proto_next = data_byte;
                        phase_next = PH_SIZE;
                    end
                    PH_SIZE:
                    begin
                        size_next = data_byte;
                        if ((proto_reg == PID_IKE && data_byte != 8'd0) ||
                            ((proto_reg inside {PID_AH, PID_ESP}) &&
                             data_byte != SPI_BYTES))
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.status = ST_BADSIZE;
                        end
                        else
                        begin
                            phase_next = PH_CNT_HI;
                        end
                    end
                    PH_CNT_HI:
                    begin
                        count_next = {data_byte, 8'h00};
                        phase_next = PH_CNT_LO;
                    end
                    PH_CNT_LO:
                    begin
                        count_next = cnt_full;
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        if (size_reg == 8'd0 && cnt_full != 16'd0)
                        begin
                            res.status = ST_BADCOUNT;
                        end
                        else if ({9'd0, len_reg} != expect_len)
                        begin
                            res.status = ST_MISMATCH;
                        end
                        else if (!(proto_reg inside {PID_IKE, PID_AH, PID_ESP}))
                        begin
                            res.status = ST_BADPROTO;
                        end
                        else if (cnt_full == 16'd0)
                        begin
                            res.status = ST_DONE;
                        end
                        else
                        begin
                            // header good, spis follow
                            res_valid  = 1'b0;
                            ctr_next   = '0;
                            bis_next   = '0;
                            shift_next = '0;
                            phase_next = PH_SPI;
                        end
                    end
                    PH_SPI:
                    begin
                        shift_next = {shift_reg[23:0], data_byte};
                        if (bis_reg != SPI_LAST_BYTE)
                        begin
                            bis_next = bis_reg + 2'd1;
                        end
                        else
                        begin
                            bis_next      = '0;
                            ctr_next      = ctr_reg + 16'd1;
                            res_valid     = 1'b1;
                            res.status    = ST_SPI;
                            res.spi_val   = {shift_reg[23:0], data_byte};
                            res.spi_index = ctr_reg;
                            res.last_flag = last_spi;
                            if (last_spi)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            proto_reg <= '0;
            size_reg  <= '0;
            count_reg <= '0;
            ctr_reg   <= '0;
            bis_reg   <= '0;
            shift_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            proto_reg <= proto_next;
            size_reg  <= size_next;
            count_reg <= count_next;
            ctr_reg   <= ctr_next;
            bis_reg   <= bis_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// File: bench/delete_payload_checker.sv
module delete_payload_checker
    import idp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    idp_byte_if         body,
    idp_result_if       result,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned words_checked,
    output bit [6:0]    status_seen
);

    // result words predicted but not yet seen, oldest first
    idp_result_t due_results[$];

    // shadow of the parser state
    logic [2:0]  phase;
    logic [15:0] decl_len;
    logic [7:0]  proto;
    logic [7:0]  spi_size;
    logic [15:0] spi_count;
    logic [15:0] spi_num;
    logic [1:0]  spi_pos;
    logic [31:0] spi_acc;

    int unsigned bad_total;
    int unsigned word_total;
    bit [6:0]    seen_mask;

    task automatic push_word(input logic [2:0] st, input logic [31:0] value,
                             input logic [15:0] idx, input logic last);
        idp_result_t w;
        w.status      = st;
        w.spi_val     = value;
        w.spi_index   = idx;
        w.proto_num   = proto;
        w.last_flag   = last;
        due_results.insert(due_results.size(), w);
    endtask

    // header check failed: one error word, then drop bytes until a start
    task automatic reject(input logic [2:0] st);
        push_word(st, 32'h0, 16'h0, 1'b1);
        phase = PH_IDLE;
    endtask

    task automatic parse_body_byte(input logic [7:0] b, input logic first);
        logic [31:0] want_len;
        logic        last;
        if (first)
        begin
            decl_len  = {b, 8'h00};
            proto     = 8'h00;
            spi_size  = 8'h00;
            spi_count = 16'h0;
            spi_num   = 16'h0;
            spi_pos   = 2'd0;
            spi_acc   = 32'h0;
            phase     = PH_LEN_LO;
        end
        else
        begin
            case (phase)
                PH_LEN_LO:
                begin
                    decl_len[7:0] = b;
                    if (decl_len < MIN_LENGTH)
                        reject(ST_SHORT);
                    else
                        phase = PH_PROTO;
                end
                PH_PROTO:
                begin
                    proto = b;
                    phase = PH_SIZE;
                end
                PH_SIZE:
                begin
                    spi_size = b;
                    if ((proto == PID_IKE && spi_size != 8'h00) ||
                        ((proto == PID_AH || proto == PID_ESP) && spi_size != SPI_BYTES))
                        reject(ST_BADSIZE);
                    else
                        phase = PH_CNT_HI;
                end
                PH_CNT_HI:
                begin
                    spi_count = {b, 8'h00};
                    phase = PH_CNT_LO;
                end
                PH_CNT_LO:
                begin
                    spi_count[7:0] = b;
                    want_len = 32'(MIN_LENGTH) + 32'(spi_count) * 32'(spi_size);
                    if (spi_size == 8'h00 && spi_count != 16'h0)
                        reject(ST_BADCOUNT);
                    else if ({16'h0, decl_len} != want_len)
                        reject(ST_MISMATCH);
                    else if (proto != PID_IKE && proto != PID_AH && proto != PID_ESP)
                        reject(ST_BADPROTO);
                    else if (spi_count == 16'h0)
                    begin
                        push_word(ST_DONE, 32'h0, 16'h0, 1'b1);
                        phase = PH_IDLE;
                    end
                    else
                    begin
                        spi_num = 16'h0;
                        spi_pos = 2'd0;
                        spi_acc = 32'h0;
                        phase   = PH_SPI;
                    end
                end
                PH_SPI:
                begin
                    spi_acc = {spi_acc[23:0], b};
                    if (spi_pos != SPI_LAST_BYTE)
                        spi_pos = spi_pos + 2'd1;
                    else
                    begin
                        spi_pos = 2'd0;
                        last = (17'(spi_num) + 17'd1) >= 17'(spi_count);
                        push_word(ST_SPI, spi_acc, spi_num, last);
                        spi_num = spi_num + 16'd1;
                        if (last)
                            phase = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            bad_total++;
            $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    task automatic check_result();
        idp_result_t want;
        idp_result_t got;
        got.status      = result.status;
        got.spi_val     = result.spi_val;
        got.spi_index   = result.spi_index;
        got.proto_num   = result.proto_num;
        got.last_flag   = result.last_flag;
        word_total++;
        if (got.status <= ST_BADPROTO)
            seen_mask[got.status] = 1'b1;
        if (due_results.size() == 0)
        begin
            bad_total++;
            $display("%0t: result word with nothing expected: status %0d spi %h idx %0d",
                     $time, got.status, got.spi_val, got.spi_index);
        end
        else
        begin
            want = due_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("spi_val", want.spi_val, got.spi_val);
            compare_field("spi_index", 32'(want.spi_index), 32'(got.spi_index));
            compare_field("proto_num", 32'(want.proto_num), 32'(got.proto_num));
            compare_field("last_flag", 32'(want.last_flag), 32'(got.last_flag));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase     = PH_IDLE;
            decl_len  = 16'h0;
            proto     = 8'h00;
            spi_size  = 8'h00;
            spi_count = 16'h0;
            spi_num   = 16'h0;
            spi_pos   = 2'd0;
            spi_acc   = 32'h0;
            due_results.delete();
        end
        else
        begin
            // results first: a word never answers a byte taken at the same edge
            if (result.valid === 1'b1 && result.ready === 1'b1)
                check_result();
            if (body.valid === 1'b1 && body.ready === 1'b1)
                parse_body_byte(body.data_byte, body.start_flag);
            mismatches    <= bad_total;
            pending       <= due_results.size();
            words_checked <= word_total;
            status_seen   <= seen_mask;
        end
    end

endmodule

// File: bench/ikev2_delete_payload_parser_top_test.sv
module ikev2_delete_payload_parser_top_test;
    import idp_pkg::*;

    logic clk;
    logic rst_n;

    idp_byte_if   body_ch ();
    idp_result_if result_ch ();

    int unsigned mismatches;
    int unsigned pending;
    int unsigned words_checked;
    bit [6:0]    status_seen;

    // bytes of the payload being assembled, sent as one run of body words
    logic [7:0] body_q[$];

    // sender stops idling for a while when set
    bit          calm;
    int unsigned body_words;
    int unsigned payloads;
    int unsigned drains;

    ikev2_delete_payload_parser_top uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_ch),
        .result (result_ch)
    );

    // watches both channels, predicts every result word and compares
    delete_payload_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .body          (body_ch),
        .result        (result_ch),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked),
        .status_seen   (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("timeout at %0t with %0d result words outstanding", $time, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic put(input logic [7:0] b);
        body_q.insert(body_q.size(), b);
    endtask

    // big-endian helpers for the 16-bit fields and the 4-byte spis
    task automatic put2(input logic [15:0] v);
        put(v[15:8]);
        put(v[7:0]);
    endtask

    task automatic put4(input logic [31:0] v);
        put2(v[31:16]);
        put2(v[15:0]);
    endtask

    // send body_q; with_start marks the first word as a payload start
    task automatic send_body(input bit with_start);
        int gap;
        if (with_start)
            payloads++;
        for (int i = 0; i < body_q.size(); i++)
        begin
            gap = idle_len(calm);
            if (gap != 0)
            begin
                body_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            body_ch.valid      <= 1'b1;
            body_ch.data_byte  <= body_q[i];
            body_ch.start_flag <= with_start && (i == 0);
            do
                @(posedge clk);
            while (body_ch.ready !== 1'b1);
            // stray bytes outside a payload don't count toward the budget
            if (with_start)
                body_words++;
        end
        body_q.delete();
    endtask

    // hold the sender until every predicted result word has come back
    task automatic wait_drained();
        body_ch.valid <= 1'b0;
        drains++;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // consistent header for ike (no spis) or ah/esp (4-byte spis)
    task automatic make_payload();
        logic [7:0] proto;
        int         count;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            proto = PID_IKE;
            count = 0;
        end
        else
        begin
            proto = ($urandom_range(0, 1) != 0) ? PID_ESP : PID_AH;
            if (r < 30)
                count = 0;
            else if (r < 90)
                count = $urandom_range(1, 3);
            else
                count = $urandom_range(4, 12);
        end
        put2(16'(8 + count * ((proto == PID_IKE) ? 0 : 4)));
        put(proto);
        put((proto == PID_IKE) ? 8'h00 : SPI_BYTES);
        put2(16'(count));
        repeat (count) put4($urandom());
    endtask

    // result side: ready bursts with random stalls, sometimes long calm runs
    initial
    begin
        int burst;
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        result_ch.ready <= 1'b1;
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                burst = $urandom_range(40, 200);
            else
                burst = $urandom_range(1, 8);
            repeat (burst) @(posedge clk);
            gap = idle_len(1'b0);
            if (gap != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int kind;
        int cut;
        logic [7:0] proto;
        logic [7:0] size;
        int count;

        rst_n              <= 1'b0;
        body_ch.valid      <= 1'b0;
        body_ch.data_byte  <= 8'h00;
        body_ch.start_flag <= 1'b0;
        calm       = 1'b0;
        body_words = 0;
        payloads   = 0;
        drains     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // a byte before any start is dropped
        put(8'hFF);
        send_body(1'b0);
        // length 7 is too short; the two bytes after the error are dropped
        put4(32'h0007_FF00);
        send_body(1'b1);
        // esp with spi size 5
        put4(32'h0008_0305);
        send_body(1'b1);
        // ike, size 0 but one spi claimed
        put4(32'h0008_0100);
        put2(16'h0001);
        send_body(1'b1);
        // ike, empty, but length 9
        put4(32'h0009_0100);
        put2(16'h0000);
        send_body(1'b1);
        // protocol 0 with a consistent empty header
        put4(32'h0008_0000);
        put2(16'h0000);
        send_body(1'b1);
        // empty ike payload gives done; the trailing byte is dropped
        put4(32'h0008_0100);
        put2(16'h0000);
        put(8'h55);
        send_body(1'b1);
        // start in mid-header: the partial payload vanishes without a word
        put2(16'h000C);
        send_body(1'b1);
        // esp with one all-ones spi
        put4(32'h000C_0304);
        put2(16'h0001);
        put4(32'hFFFF_FFFF);
        send_body(1'b1);
        wait_drained();

        // --- random part ---
        while (body_words < 1150)
        begin
            if ($urandom_range(0, 9) == 0)
                calm = ~calm;
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // well-formed, maybe followed by junk that must be ignored
                make_payload();
                send_body(1'b1);
                if ($urandom_range(0, 6) == 0)
                begin
                    repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
                    send_body(1'b0);
                end
            end
            else if (kind < 70)
            begin
                // one header byte replaced by a random one
                make_payload();
                body_q[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
                send_body(1'b1);
            end
            else if (kind < 82)
            begin
                // cut short; the next start abandons it
                make_payload();
                cut = $urandom_range(1, body_q.size() - 1);
                while (body_q.size() > cut)
                    void'(body_q.pop_back());
                send_body(1'b1);
            end
            else if (kind < 92)
            begin
                // unknown protocol with a length that matches size and count
                proto = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(4, 255));
                size  = 8'($urandom_range(0, 255));
                count = $urandom_range(0, 3);
                put2(16'(8 + count * int'(size)));
                put(proto);
                put(size);
                put2(16'(count));
                send_body(1'b1);
            end
            else
            begin
                // loose bytes with no start
                repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
                send_body(1'b0);
            end
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (4) @(posedge clk);

        $display("run: %0d body words over %0d payloads, %0d result words compared",
                 body_words, payloads, words_checked);
        $display("status codes seen (bit n = code n): %b, sender held for drain %0d times",
                 status_seen, drains);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
